/* src/ialu_pkg.sv */
// Shared types and constants for the signed integer ALU.
// Holds the operation, status and sequencer codes and the divider result.
// No dependencies.
package ialu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_POW  = 4'd5,
    OP_MIN  = 4'd6,
    OP_MAX  = 4'd7,
    OP_MEAN = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_EXP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_POW_MUL,
    S_POW_SQ
  } state_e;

  // Signed quotient and remainder from the divider
  typedef struct packed {
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } div_res_t;

endpackage

/* src/ialu_div.sv */
// Iterative signed divider: one restoring step per cycle.
// Quotient truncates toward zero, remainder takes the dividend's sign.
// Depends on ialu_pkg.
module ialu_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ialu_pkg::DataW-1:0] dividend_i,
  input  logic [ialu_pkg::DataW-1:0] divisor_i,
  output logic                     done_o,
  output ialu_pkg::div_res_t       res_o
);
  import ialu_pkg::*;

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] q_q, q_d;
  logic [DataW-1:0] r_q, r_d;
  logic [DataW-1:0] d_q, d_d;
  logic             negq_q, negq_d;
  logic             negr_q, negr_d;
  logic [DataW:0]   trial;
  logic             borrow;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial  = {r_q, q_q[DataW-1]} - {1'b0, d_q};
  assign borrow = trial[DataW];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    negq_d = negq_q;
    negr_d = negr_q;
    if (start_i) begin
      // Load magnitudes and remember result signs
      run_d  = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      q_d    = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      d_d    = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;
      negq_d = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      negr_d = dividend_i[DataW-1];
    end else if (run_q) begin
      // Advance one quotient bit
      r_d   = borrow ? {r_q[DataW-2:0], q_q[DataW-1]} : trial[DataW-1:0];
      q_d   = {q_q[DataW-2:0], ~borrow};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    r_q    <= r_d;
    d_q    <= d_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  // Apply signs to the finished magnitudes
  assign done_o     = done_q;
  assign res_o.quot = negq_q ? (~q_q + 1'b1) : q_q;
  assign res_o.rem  = negr_q ? (~r_q + 1'b1) : r_q;

endmodule

/* src/integer_alu_with_pow_and_mean_core.sv */
// Top level of the signed 32-bit integer ALU with power and mean.
// Depends on ialu_pkg and ialu_div.
//
// Usage:
//   Drive operation_i, operand_a_i and operand_b_i and raise start while
//   busy is low; the beat is taken at that clock edge. Each command yields
//   exactly one result beat on value_o/status_o, marked by valid_o for one
//   cycle. The receiver cannot stall, so the result must be taken then.
// Sequencing:
//   add, sub, mul, min, max, mean, every error case: result in the cycle
//   after the command; busy stays low, so a command may follow each cycle.
//   div, mod: the one-bit-per-cycle restoring divider runs, then the
//   sequencer registers the quotient or remainder as the result.
//   pow: square-and-multiply over an exponent of up to 31 bits, on the single
//   32x32 multiplier that alternates between the multiply and square steps.
//   busy is high while div, mod or pow is in progress.
// Reset:
//   rst_ni clears the sequencer and the result strobe; no command is
//   pending after reset.
module integer_alu_with_pow_and_mean_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [3:0]                         operation_i,
  input  logic signed [ialu_pkg::DataW-1:0]  operand_a_i,
  input  logic signed [ialu_pkg::DataW-1:0]  operand_b_i,
  output logic                               valid_o,
  output logic signed [ialu_pkg::DataW-1:0]  value_o,
  output logic [1:0]                         status_o
);
  import ialu_pkg::*;

  state_e           state_q, state_d;
  logic             valid_q, valid_d;
  logic [DataW-1:0] value_q, value_d;
  status_e          status_q, status_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] sq_q, sq_d;
  logic [DataW-2:0] exp_q, exp_d;
  logic             mod_q, mod_d;

  logic [DataW-1:0] mul_x, mul_y, mul_p;
  logic [DataW-1:0] sum, diff;
  logic [DataW:0]   mean_sum;
  logic             a_lt_b;
  logic             div_start, div_done;
  div_res_t         div_res;
  op_e              op;

  assign op = op_e'(operation_i);

  // Shared divider
  ialu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (operand_a_i),
    .divisor_i  (operand_b_i),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // Select multiplier operands: command operands, multiply step or square step
  always_comb begin
    unique case (state_q)
      S_POW_MUL: begin
        mul_x = acc_q;
        mul_y = sq_q;
      end
      S_POW_SQ: begin
        mul_x = sq_q;
        mul_y = sq_q;
      end
      default: begin
        mul_x = operand_a_i;
        mul_y = operand_b_i;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // Combinational datapath
  assign sum      = operand_a_i + operand_b_i;
  assign diff     = operand_a_i - operand_b_i;
  assign a_lt_b   = operand_a_i < operand_b_i;
  assign mean_sum = {sum[DataW-1], sum} + {{DataW{1'b0}}, sum[DataW-1]};

  // Sequencer: next state and result
  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    value_d   = value_q;
    status_d  = status_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    exp_d     = exp_q;
    mod_d     = mod_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          valid_d  = 1'b1;
          status_d = ST_OK;
          value_d  = '0;
          unique case (op)
            OP_ADD:  value_d = sum;
            OP_SUB:  value_d = diff;
            OP_MUL:  value_d = mul_p;
            OP_MIN:  value_d = a_lt_b ? operand_a_i : operand_b_i;
            OP_MAX:  value_d = a_lt_b ? operand_b_i : operand_a_i;
            OP_MEAN: value_d = mean_sum[DataW:1];
            OP_DIV, OP_MOD: begin
              if (operand_b_i == '0) begin
                status_d = ST_DIV_ZERO;
              end else begin
                valid_d   = 1'b0;
                div_start = 1'b1;
                mod_d     = (op == OP_MOD);
                state_d   = S_DIV;
              end
            end
            OP_POW: begin
              if (operand_b_i[DataW-1]) begin
                status_d = ST_BAD_EXP;
              end else begin
                valid_d = 1'b0;
                acc_d   = DataW'(1);
                sq_d    = operand_a_i;
                exp_d   = operand_b_i[DataW-2:0];
                state_d = S_POW_MUL;
              end
            end
            default: value_d = '0;
          endcase
        end
      end
      S_DIV: begin
        // Wait for the divider, then pick quotient or remainder
        if (div_done) begin
          value_d  = mod_q ? div_res.rem : div_res.quot;
          status_d = ST_OK;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_POW_MUL: begin
        // Fold in the current base power when the exponent bit is set
        if (exp_q[0]) begin
          acc_d = mul_p;
        end
        if (exp_q[DataW-2:1] == '0) begin
          value_d  = exp_q[0] ? mul_p : acc_q;
          status_d = ST_OK;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        // Square the base and drop the consumed exponent bit
        sq_d    = mul_p;
        exp_d   = exp_q >> 1;
        state_d = S_POW_MUL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    exp_q    <= exp_d;
    mod_q    <= mod_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

  // A zero divisor reports at once with the error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_DIV || operation_i == OP_MOD)
     && operand_b_i == '0) |=> (valid_o && status_o == ST_DIV_ZERO))
    else $error("zero divisor did not report divide_by_zero");

  // An error result always carries value zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (value_o == '0))
    else $error("error result with nonzero value");

  // No result beat while a long operation is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result strobe while busy");

  // A long operation ends with a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("long operation finished without a result");

endmodule
